// ===== rtl/fgn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types and constants of the fractal gradient noise unit.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE_FREQ = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_AMP  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OCT_COUNT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ_GAIN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_GAIN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED      = 3'd5;

  localparam logic [31:0] BASE_FREQ_RST = 32'd42949673;
  localparam logic [31:0] BASE_AMP_RST  = 32'd65536;
  localparam logic [3:0]  OCT_COUNT_RST = 4'd1;
  localparam logic [15:0] FREQ_GAIN_RST = 16'd8192;
  localparam logic [16:0] AMP_GAIN_RST  = 17'd32768;
  localparam logic [31:0] SEED_RST      = 32'd0;

  localparam logic [16:0] AMP_GAIN_ONE = 17'd65536;
  localparam logic [47:0] FREQ_MAX     = 48'hFFFF_FFFF_FFFF;

  // corner hash multipliers; only their low two bits reach the gradient pick
  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;

  localparam logic [1:0] GRAD_PP = 2'd0;
  localparam logic [1:0] GRAD_NP = 2'd1;
  localparam logic [1:0] GRAD_PN = 2'd2;
  localparam logic [1:0] GRAD_NN = 2'd3;

  typedef struct packed {
    logic [15:0] freq_gain;
    logic [16:0] amp_gain;
    logic [3:0]  oct_count;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [47:0]        freq;
    logic [31:0]        amp;
    logic signed [47:0] total;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/fgn_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_cell
// One octave: scale, split, corner gradients, fade, blend, weight, accumulate.
// ----------------------------------------------------------------------------
module fgn_cell #(
  parameter int OCTAVE        = 0,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ce,
  input  wire fgn_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire fgn_pkg::item_t in_item,
  output logic               out_valid,
  output fgn_pkg::item_t     out_item
);

  localparam int FB  = FRACTION_BITS;
  localparam int NST = 9;
  localparam int DW  = FB + 3;
  localparam int EW  = FB + 3;
  localparam int TW  = EW + 33 - FB;
  localparam logic [FB+3:0] FIFTEEN_S = (FB+4)'(15) << FB;
  localparam logic [FB+3:0] TEN_S     = (FB+4)'(10) << FB;
  localparam logic signed [DW-1:0] ONE_D = DW'(1) << FB;
  localparam logic [1:0] OCT_LO = 2'(OCTAVE);
  localparam logic [3:0] OCT_ID = 4'(OCTAVE);
  localparam logic [1:0] HX = fgn_pkg::HASH_MUL_X[1:0];
  localparam logic [1:0] HY = fgn_pkg::HASH_MUL_Y[1:0];

  function automatic logic signed [DW-1:0] grad_dot(input logic [1:0] sel,
      input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
    logic signed [DW-1:0] r;
    unique case (sel)
      fgn_pkg::GRAD_PP: r = dx + dy;
      fgn_pkg::GRAD_NP: r = dy - dx;
      fgn_pkg::GRAD_PN: r = dx - dy;
      fgn_pkg::GRAD_NN: r = -dx - dy;
      default:          r = '0;
    endcase
    return r;
  endfunction

  logic [NST-1:0]  vld_r;
  fgn_pkg::item_t  item_r [NST];
  logic [31:0]     amp_n_r [7];

  // stage 1
  logic signed [64:0] ax_p, ay_p;
  logic signed [48:0] bx_p, by_p;
  logic [63:0]        fp_p;
  logic [48:0]        ap_p;
  logic [33:0]        ax_r, ay_r;
  logic [1:0]         bx_r, by_r;
  logic [63:0]        fp_r;
  logic [48:0]        ap_r;

  // stage 2
  logic [1:0]    cxl, cyl, hs;
  logic [47:0]   freq_nxt;
  fgn_pkg::item_t item1_nxt;
  logic [FB-1:0] t2s_r [2];
  logic [1:0]    sel_r [4];

  // stage 3..5
  logic signed [DW-1:0] dxa, dxb, dya, dyb;
  logic [2*FB-1:0] tt_p [2];
  logic [2*FB+3:0] m_p [2];
  logic [FB-1:0]   t3s_r [2];
  logic [FB-1:0]   tsq_r [2];
  logic [FB+3:0]   m_r [2];
  logic signed [DW-1:0] d3_r [4];
  logic signed [DW-1:0] d4_r [4];
  logic signed [DW-1:0] d5_r [4];
  logic [2*FB-1:0] tc_p [2];
  logic [FB-1:0]   tcu_r [2];
  logic [FB+3:0]   inner_r [2];
  logic [2*FB+3:0] f_p [2];
  logic [FB:0]     fade_r [2];

  // stage 6..9
  logic signed [EW-1:0]     dif0, dif1;
  logic signed [2*FB+4:0]   b0_p, b1_p;
  logic signed [EW-1:0]     e0_r, e1_r;
  logic [FB:0]              v6_r;
  logic signed [FB+3:0]     dif2;
  logic signed [2*FB+5:0]   n_p;
  logic signed [EW-1:0]     n7_r;
  logic signed [EW+32:0]    w_p;
  logic signed [TW-1:0]     term8_r;
  logic                     act;
  logic signed [48:0]       sum;
  logic signed [47:0]       total_nxt;
  fgn_pkg::item_t           item8_nxt;

  assign act = OCT_ID < cfg.oct_count;

  always_comb begin
    ax_p = $signed(in_item.x) * $signed({1'b0, in_item.freq[31:0]});
    ay_p = $signed(in_item.y) * $signed({1'b0, in_item.freq[31:0]});
    bx_p = $signed(in_item.x) * $signed({1'b0, in_item.freq[47:32]});
    by_p = $signed(in_item.y) * $signed({1'b0, in_item.freq[47:32]});
    fp_p = in_item.freq * cfg.freq_gain;
    ap_p = in_item.amp * cfg.amp_gain;
  end

  always_comb begin
    cxl = ax_r[33:32] + bx_r;
    cyl = ay_r[33:32] + by_r;
    hs  = 2'(cxl * HX) + 2'(cyl * HY) + cfg.seed[1:0] + OCT_LO;
    if (fp_r[63:60] != 4'd0) begin
      freq_nxt = fgn_pkg::FREQ_MAX;
    end else begin
      freq_nxt = fp_r[59:12];
    end
    item1_nxt      = item_r[0];
    item1_nxt.freq = freq_nxt;
  end

  always_comb begin
    dxa = $signed({3'b000, t2s_r[0]});
    dya = $signed({3'b000, t2s_r[1]});
    dxb = dxa - ONE_D;
    dyb = dya - ONE_D;
    for (int i = 0; i < 2; i++) begin
      tt_p[i] = t2s_r[i] * t2s_r[i];
      m_p[i]  = t2s_r[i] * (FIFTEEN_S - (FB+4)'({t2s_r[i], 2'b00})
                - (FB+4)'({t2s_r[i], 1'b0}));
      tc_p[i] = tsq_r[i] * t3s_r[i];
      f_p[i]  = tcu_r[i] * inner_r[i];
    end
  end

  always_comb begin
    dif0 = EW'(d5_r[1]) - EW'(d5_r[0]);
    dif1 = EW'(d5_r[3]) - EW'(d5_r[2]);
    b0_p = $signed({1'b0, fade_r[0]}) * dif0;
    b1_p = $signed({1'b0, fade_r[0]}) * dif1;
    dif2 = (FB+4)'(e1_r) - (FB+4)'(e0_r);
    n_p  = $signed({1'b0, v6_r}) * dif2;
    w_p  = n7_r * $signed({1'b0, item_r[6].amp});
    sum  = 49'(item_r[7].total) + 49'(term8_r);
    if (sum[48] != sum[47]) begin
      total_nxt = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      total_nxt = sum[47:0];
    end
    item8_nxt       = item_r[7];
    item8_nxt.amp   = amp_n_r[6];
    item8_nxt.total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_r[0] <= in_item;
      ax_r <= ax_p[33:0];
      ay_r <= ay_p[33:0];
      bx_r <= bx_p[1:0];
      by_r <= by_p[1:0];
      fp_r <= fp_p;
      ap_r <= ap_p;

      item_r[1]      <= item1_nxt;
      amp_n_r[0]     <= ap_r[47:16];
      t2s_r[0]       <= ax_r[31:32-FB];
      t2s_r[1]       <= ay_r[31:32-FB];
      sel_r[0]       <= hs;
      sel_r[1]       <= hs + HX;
      sel_r[2]       <= hs + HY;
      sel_r[3]       <= hs + HX + HY;

      for (int i = 2; i < NST - 1; i++) begin
        item_r[i] <= item_r[i-1];
      end
      for (int i = 1; i < 7; i++) begin
        amp_n_r[i] <= amp_n_r[i-1];
      end

      d3_r[0] <= grad_dot(sel_r[0], dxa, dya);
      d3_r[1] <= grad_dot(sel_r[1], dxb, dya);
      d3_r[2] <= grad_dot(sel_r[2], dxa, dyb);
      d3_r[3] <= grad_dot(sel_r[3], dxb, dyb);
      for (int i = 0; i < 2; i++) begin
        t3s_r[i]   <= t2s_r[i];
        tsq_r[i]   <= tt_p[i][2*FB-1:FB];
        m_r[i]     <= m_p[i][2*FB+3:FB];
        tcu_r[i]   <= tc_p[i][2*FB-1:FB];
        inner_r[i] <= TEN_S - m_r[i];
        fade_r[i]  <= f_p[i][2*FB:FB];
      end
      for (int i = 0; i < 4; i++) begin
        d4_r[i] <= d3_r[i];
        d5_r[i] <= d4_r[i];
      end

      e0_r <= EW'(d5_r[0]) + $signed(b0_p[FB+EW-1:FB]);
      e1_r <= EW'(d5_r[2]) + $signed(b1_p[FB+EW-1:FB]);
      v6_r <= fade_r[1];
      n7_r <= e0_r + $signed(n_p[FB+EW-1:FB]);
      term8_r <= act ? $signed(w_p[FB+TW-1:FB]) : '0;

      item_r[NST-1] <= item8_nxt;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_item  = item_r[NST-1];

  a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && ce |=> vld_r[0] == $past(in_valid))
    else $error("first stage valid does not follow the accepted request");
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !ce |=> $stable(vld_r))
    else $error("stage valids moved while stalled");
  a_idle_octave: assert property (@(posedge clk) disable iff (!rst_n)
    ce && !act |=> term8_r == '0)
    else $error("inactive octave contributed to the sum");

endmodule
`default_nettype wire

// ===== rtl/fractal_gradient_noise_2d_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d_unit
// Fractal 2D gradient noise, one octave cell per octave in a chain.
//
//   channel  dir  payload
//   in_      in   tdata[31:0] coord_x, tdata[63:32] coord_y
//   out_     out  tdata[47:0] noise_value
//   cfg_     in   register index, 32-bit write data
//
// One request per cycle while no result waits unread; each octave cell in the
// chain has nine stages.
// All stages advance together; the chain holds while a result waits unread.
// Reset clears the stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d_unit #(
  parameter int MAX_OCTAVES   = 8,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // coord_x, coord_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // noise_value
  input  wire logic        cfg_we,
  input  wire logic [fgn_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [fgn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [31:0] base_freq_r, base_freq_nxt;
  logic [31:0] base_amp_r, base_amp_nxt;
  logic [3:0]  oct_count_r, oct_count_nxt;
  logic [15:0] freq_gain_r, freq_gain_nxt;
  logic [16:0] amp_gain_r, amp_gain_nxt;
  logic [31:0] seed_r, seed_nxt;

  fgn_pkg::cfg_t  cfg;
  fgn_pkg::item_t link [MAX_OCTAVES+1];
  logic           lvld [MAX_OCTAVES+1];
  logic           ce;

  always_comb begin
    base_freq_nxt = base_freq_r;
    base_amp_nxt  = base_amp_r;
    oct_count_nxt = oct_count_r;
    freq_gain_nxt = freq_gain_r;
    amp_gain_nxt  = amp_gain_r;
    seed_nxt      = seed_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        fgn_pkg::REG_BASE_FREQ: base_freq_nxt = cfg_wdata;
        fgn_pkg::REG_BASE_AMP:  base_amp_nxt  = cfg_wdata;
        fgn_pkg::REG_OCT_COUNT: oct_count_nxt = cfg_wdata[3:0];
        fgn_pkg::REG_FREQ_GAIN: freq_gain_nxt = cfg_wdata[15:0];
        fgn_pkg::REG_AMP_GAIN:  amp_gain_nxt  = cfg_wdata[16:0];
        fgn_pkg::REG_SEED:      seed_nxt      = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_freq_r <= fgn_pkg::BASE_FREQ_RST;
      base_amp_r  <= fgn_pkg::BASE_AMP_RST;
      oct_count_r <= fgn_pkg::OCT_COUNT_RST;
      freq_gain_r <= fgn_pkg::FREQ_GAIN_RST;
      amp_gain_r  <= fgn_pkg::AMP_GAIN_RST;
      seed_r      <= fgn_pkg::SEED_RST;
    end else begin
      base_freq_r <= base_freq_nxt;
      base_amp_r  <= base_amp_nxt;
      oct_count_r <= oct_count_nxt;
      freq_gain_r <= freq_gain_nxt;
      amp_gain_r  <= amp_gain_nxt;
      seed_r      <= seed_nxt;
    end
  end

  always_comb begin
    cfg.freq_gain = freq_gain_r;
    cfg.amp_gain  = (amp_gain_r > fgn_pkg::AMP_GAIN_ONE) ? fgn_pkg::AMP_GAIN_ONE
                                                         : amp_gain_r;
    cfg.oct_count = oct_count_r;
    cfg.seed      = seed_r;
  end

  assign ce        = out_tready | ~out_tvalid;
  assign in_tready = ce;

  always_comb begin
    link[0].x     = $signed(in_tdata[31:0]);
    link[0].y     = $signed(in_tdata[63:32]);
    link[0].freq  = {16'd0, base_freq_r};
    link[0].amp   = base_amp_r;
    link[0].total = '0;
    lvld[0]       = in_tvalid;
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fgn_cell #(
      .OCTAVE       (k),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (ce),
      .cfg      (cfg),
      .in_valid (lvld[k]),
      .in_item  (link[k]),
      .out_valid(lvld[k+1]),
      .out_item (link[k+1])
    );
  end

  assign out_tvalid = lvld[MAX_OCTAVES];
  assign out_tdata  = link[MAX_OCTAVES].total;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== verif/tb_fractal_gradient_noise_2d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractal_gradient_noise_2d_unit
// Self-checking bench for the fractal gradient noise unit: coordinate
// requests stream in with random gaps, an in-bench predictor computes the
// summed octave noise for each accepted request, and the monitor compares
// every result against the oldest prediction across several register sets.
// ----------------------------------------------------------------------------
module tb_fractal_gradient_noise_2d_unit;
  import fgn_pkg::*;

  localparam int MAX_OCT = 8;
  localparam int FB      = 16;
  localparam int LATENCY = 9 * MAX_OCT;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint OUT_HI = (64'sd1 <<< 47) - 1;
  localparam longint OUT_LO = -(64'sd1 <<< 47);

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;   // coord_x, coord_y
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;  // noise_value
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [31:0] m_base_freq, m_base_amp, m_seed;
  logic [3:0]  m_oct;
  logic [15:0] m_fgain;
  logic [16:0] m_again;

  logic [63:0] coord_q[$];
  logic [47:0] noise_q[$];
  int errors;
  bit no_idle;
  bit hold_off;
  int hold_cnt;

  fractal_gradient_noise_2d_unit u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_sh(longint v);
    return v >>> FB;
  endfunction

  function automatic longint fade_fx(longint t);
    longint t2, t3, inner;
    t2 = (t * t) >>> FB;
    t3 = (t2 * t) >>> FB;
    inner = 10 * ONE - ((t * (15 * ONE - 6 * t)) >>> FB);
    return (t3 * inner) >>> FB;
  endfunction

  function automatic longint grad_dot(logic [31:0] cx, logic [31:0] cy, longint dx,
                                      longint dy, logic [31:0] seed);
    logic [31:0] h;
    h = cx * HASH_MUL_X + cy * HASH_MUL_Y + seed;
    case (h[1:0])
      GRAD_PP: return dx + dy;
      GRAD_NP: return -dx + dy;
      GRAD_PN: return dx - dy;
      default: return -dx - dy;
    endcase
  endfunction

  function automatic longint lerp_fx(longint a, longint b, longint f);
    return a + floor_sh(f * (b - a));
  endfunction

  function automatic logic [47:0] predict_noise(logic [63:0] coord);
    logic [63:0] px, py;
    logic [31:0] cx, cy;
    longint tx, ty, n00, n10, n01, n11, u, v, n, total;
    logic [63:0] freq, amp, ag;
    int cnt;
    cnt = (m_oct > MAX_OCT) ? MAX_OCT : m_oct;
    ag = (m_again > AMP_GAIN_ONE) ? 64'(AMP_GAIN_ONE) : 64'(m_again);
    freq = m_base_freq;
    amp = m_base_amp;
    total = 0;
    for (int k = 0; k < cnt; k++) begin
      px = 64'($signed(coord[31:0])) * freq;
      py = 64'($signed(coord[63:32])) * freq;
      cx = px[63:32];
      cy = py[63:32];
      tx = longint'(px[31:32-FB]);
      ty = longint'(py[31:32-FB]);
      n00 = grad_dot(cx, cy, tx, ty, m_seed + k);
      n10 = grad_dot(cx + 1, cy, tx - ONE, ty, m_seed + k);
      n01 = grad_dot(cx, cy + 1, tx, ty - ONE, m_seed + k);
      n11 = grad_dot(cx + 1, cy + 1, tx - ONE, ty - ONE, m_seed + k);
      u = fade_fx(tx);
      v = fade_fx(ty);
      n = lerp_fx(lerp_fx(n00, n10, u), lerp_fx(n01, n11, u), v);
      total += floor_sh(n * longint'(amp));
      if (total > OUT_HI) total = OUT_HI;
      if (total < OUT_LO) total = OUT_LO;
      freq = (freq * m_fgain) >> 12;
      if (freq > 64'(FREQ_MAX)) freq = FREQ_MAX;
      amp = (amp * ag) >> 16;
    end
    return total[47:0];
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) noise_q.push_back(predict_noise(in_tdata));
      if (coord_q.size() > 0 && (no_idle || $urandom_range(99) >= 9)) begin
        in_tvalid <= 1'b1;
        in_tdata <= coord_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected result %h", out_tdata);
          errors++;
        end else begin
          logic [47:0] exp_v;
          exp_v = noise_q.pop_front();
          if (out_tdata !== exp_v) begin
            $error("noise_value: expected %h actual %h", exp_v, out_tdata);
            errors++;
          end
        end
      end
      if (hold_off && hold_cnt < 400) begin
        hold_cnt <= hold_cnt + 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || $urandom_range(99) >= 9;
      end
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_FREQ: m_base_freq = val;
      REG_BASE_AMP:  m_base_amp = val;
      REG_OCT_COUNT: m_oct = val[3:0];
      REG_FREQ_GAIN: m_fgain = val[15:0];
      REG_AMP_GAIN:  m_again = val[16:0];
      REG_SEED:      m_seed = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (coord_q.size() > 0 || in_tvalid || noise_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_cfg();
    write_reg(REG_BASE_FREQ, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 28));
    write_reg(REG_BASE_AMP, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
    write_reg(REG_OCT_COUNT, $urandom_range(15));
    write_reg(REG_FREQ_GAIN, $urandom_range(3) == 0 ? $urandom_range(65535)
                                                     : $urandom_range(4096, 12288));
    write_reg(REG_AMP_GAIN, $urandom_range(3) == 0 ? $urandom_range(131071)
                                                    : $urandom_range(65536));
    write_reg(REG_SEED, $urandom);
  endtask

  task automatic push_random(int n);
    logic [31:0] x, y;
    repeat (n) begin
      case ($urandom_range(3))
        0: begin x = $urandom; y = $urandom; end
        1: begin x = $urandom_range(2000) - 1000; y = $urandom_range(2000) - 1000; end
        default: begin x = $urandom_range(1 << 20); y = -$urandom_range(1 << 20); end
      endcase
      coord_q.push_back({y, x});
    end
  endtask

  initial begin
    errors = 0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    m_base_freq = BASE_FREQ_RST;
    m_base_amp = BASE_AMP_RST;
    m_oct = OCT_COUNT_RST;
    m_fgain = FREQ_GAIN_RST;
    m_again = AMP_GAIN_RST;
    m_seed = SEED_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, coordinate extremes
    coord_q.push_back({32'h0, 32'h0});
    coord_q.push_back({32'h7FFF_FFFF, 32'h8000_0000});
    coord_q.push_back({32'h8000_0000, 32'h7FFF_FFFF});
    coord_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
    coord_q.push_back({32'hAAAA_AAAA, 32'h5555_5555});
    coord_q.push_back({32'd50, 32'd99});
    drain();
    // zero octaves
    write_reg(REG_OCT_COUNT, 0);
    coord_q.push_back({32'd123, 32'd456});
    coord_q.push_back({32'hFFFF_0000, 32'h1234});
    drain();
    // extremes: octave count above max, amp gain above one, freq saturation,
    // sum saturation, ignored index
    write_reg(REG_OCT_COUNT, 15);
    write_reg(REG_AMP_GAIN, 17'h1FFFF);
    write_reg(REG_FREQ_GAIN, 16'hFFFF);
    write_reg(REG_BASE_FREQ, 32'hFFFF_FFFF);
    write_reg(REG_BASE_AMP, 32'hFFFF_FFFF);
    write_reg(REG_SEED, 32'h8000_0000);
    write_reg(3'd7, 32'hDEAD_BEEF);
    coord_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF});
    coord_q.push_back({32'h8000_0000, 32'h8000_0000});
    coord_q.push_back({32'h1234_5678, 32'h8765_4321});
    coord_q.push_back({32'd3, 32'd1});
    drain();
    write_reg(REG_FREQ_GAIN, 0);
    write_reg(REG_AMP_GAIN, 0);
    write_reg(REG_BASE_FREQ, 0);
    write_reg(REG_SEED, 32'h7FFF_FFFF);
    coord_q.push_back({32'd77, 32'hFFFF_FFF0});
    coord_q.push_back({32'hC000_0000, 32'd5});
    drain();

    // random phases; stall output long once, run one phase without gaps
    for (int ph = 0; ph < 12; ph++) begin
      random_cfg();
      no_idle = (ph == 3);
      hold_off = (ph == 1);
      push_random(160);
      drain();
      hold_off = 1'b0;
    end

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
